[hw/rtl/smpc_pkg.sv]
// ----------------------------------------------------------------------------
// smpc_pkg
// Types and constants shared by the soil moisture pump controller.
// ----------------------------------------------------------------------------
package smpc_pkg;

    localparam int TIME_W     = 32;
    localparam int MOIST_W    = 16;
    localparam int THRESH_W   = 7;
    localparam int INTERVAL_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Largest valid moisture sample in percent
    localparam logic signed [MOIST_W-1:0] MOISTURE_MAX = 16'sd100;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WATER_DURATION = 2'd3;

    // Configuration reset values
    localparam logic [THRESH_W-1:0]   LOW_THRESHOLD_RST  = 7'd30;
    localparam logic [THRESH_W-1:0]   HIGH_THRESHOLD_RST = 7'd70;
    localparam logic [INTERVAL_W-1:0] CHECK_INTERVAL_RST = 16'd60;
    localparam logic [INTERVAL_W-1:0] WATER_DURATION_RST = 16'd10;

    typedef enum logic [1:0] {
        IND_NORMAL    = 2'd0,
        IND_WATERING  = 2'd1,
        IND_LOW_ALERT = 2'd2,
        IND_ERROR     = 2'd3
    } indicator_t;

    typedef struct packed {
        logic [THRESH_W-1:0]   low_threshold;
        logic [THRESH_W-1:0]   high_threshold;
        logic [INTERVAL_W-1:0] check_interval_s;
        logic [INTERVAL_W-1:0] watering_duration_s;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] last_check_time;
        logic [TIME_W-1:0] pump_start_time;
        logic [TIME_W-1:0] last_water_time;
        logic              pump_on;
        logic              manual_mode;
        indicator_t        indicator;
    } ctrl_state_t;

endpackage

[hw/rtl/smpc_if.sv]
// ----------------------------------------------------------------------------
// smpc_if
// Valid/ready channels carrying sample requests and controller results.
// ----------------------------------------------------------------------------
interface smpc_sample_if;
    import smpc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [TIME_W-1:0]         now_seconds;
    logic signed [MOIST_W-1:0] moisture_percent;
    logic                      manual_request;

    modport source (output valid, output now_seconds, output moisture_percent,
                    output manual_request, input ready);
    modport sink   (input valid, input now_seconds, input moisture_percent,
                    input manual_request, output ready);
endinterface

interface smpc_result_if;
    logic       valid;
    logic       ready;
    logic       pump_running;
    logic [1:0] indicator;
    logic       manual_active;
    logic       sensor_fault;

    modport source (output valid, output pump_running, output indicator,
                    output manual_active, output sensor_fault, input ready);
    modport sink   (input valid, input pump_running, input indicator,
                    input manual_active, input sensor_fault, output ready);
endinterface

[hw/rtl/smpc_pass.sv]
// ----------------------------------------------------------------------------
// smpc_pass
// One controller pass: next state and fault flag from state, config, sample.
// ----------------------------------------------------------------------------
module smpc_pass
    import smpc_pkg::*;
(
    input  ctrl_state_t               state,
    input  cfg_t                      cfg,
    input  logic [TIME_W-1:0]         now_seconds,
    input  logic signed [MOIST_W-1:0] moisture_percent,
    input  logic                      manual_request,
    output ctrl_state_t               state_next,
    output logic                      fault
);

    logic [TIME_W-1:0]   since_check;
    logic [TIME_W-1:0]   since_start;
    logic [TIME_W-1:0]   since_water;
    logic [TIME_W-1:0]   since_start_mid;
    logic [TIME_W-1:0]   interval_ext;
    logic [TIME_W-1:0]   duration_ext;
    logic [THRESH_W-1:0] moist_lo;
    logic                manual_eff;
    logic                check_due;
    logic                is_low;
    logic                is_high;
    ctrl_state_t         mid;

    assign interval_ext = {{(TIME_W-INTERVAL_W){1'b0}}, cfg.check_interval_s};
    assign duration_ext = {{(TIME_W-INTERVAL_W){1'b0}}, cfg.watering_duration_s};
    assign since_check  = now_seconds - state.last_check_time;
    assign since_start  = now_seconds - state.pump_start_time;
    assign since_water  = now_seconds - state.last_water_time;

    assign fault      = (moisture_percent < 16'sd0) || (moisture_percent > MOISTURE_MAX);
    // In range the sample fits in seven bits
    assign moist_lo   = moisture_percent[THRESH_W-1:0];
    assign is_low     = moist_lo < cfg.low_threshold;
    assign is_high    = moist_lo > cfg.high_threshold;
    assign manual_eff = state.manual_mode | manual_request;
    assign check_due  = since_check >= interval_ext;

    // Automatic check, before the final run-time check
    always_comb
    begin
        mid = state;
        if (check_due)
        begin
            mid.last_check_time = now_seconds;
            if (is_low && (since_water >= interval_ext))
            begin
                mid.pump_on         = 1'b1;
                mid.indicator       = IND_WATERING;
                mid.pump_start_time = now_seconds;
                mid.last_water_time = now_seconds;
            end
            else if (is_high)
            begin
                mid.pump_on   = 1'b0;
                mid.indicator = IND_NORMAL;
            end
            else if (is_low)
            begin
                mid.indicator = IND_LOW_ALERT;
            end
            else if (!state.pump_on)
            begin
                mid.indicator = IND_NORMAL;
            end
        end
    end

    assign since_start_mid = now_seconds - mid.pump_start_time;

    always_comb
    begin
        state_next = state;
        if (fault)
        begin
            state_next.indicator   = IND_ERROR;
            state_next.pump_on     = 1'b0;
            state_next.manual_mode = 1'b0;
        end
        else if (manual_eff)
        begin
            state_next.manual_mode = 1'b1;
            if (!state.pump_on)
            begin
                state_next.pump_on         = 1'b1;
                state_next.indicator       = IND_WATERING;
                state_next.pump_start_time = now_seconds;
                state_next.last_water_time = now_seconds;
            end
            else if (since_start >= duration_ext)
            begin
                state_next.pump_on     = 1'b0;
                state_next.indicator   = IND_NORMAL;
                state_next.manual_mode = 1'b0;
            end
        end
        else
        begin
            state_next = mid;
            if (mid.pump_on && (since_start_mid >= duration_ext))
            begin
                state_next.pump_on   = 1'b0;
                state_next.indicator = IND_NORMAL;
            end
        end
    end

endmodule

[hw/rtl/soil_moisture_pump_controller.sv]
// ----------------------------------------------------------------------------
// soil_moisture_pump_controller
// Pump controller: one moisture sample request in, one pump result out.
// ----------------------------------------------------------------------------
// Usage:
//   sample  - valid/ready request channel carrying now_seconds,
//             moisture_percent and manual_request. A request is taken at a
//             rising edge where valid and ready are both high.
//   result  - valid/ready channel carrying pump_running, indicator,
//             manual_active and sensor_fault, one result per request.
//   cfg_*   - plain write port for the four control registers; write only
//             while no request is in flight.
// Path: a request sits in the input register, the pass logic evaluates
//   it and the result register takes the result when the pass stage
//   advances.
// Throughput: one request per cycle while results are taken; the pass
//   logic is combinational, so back-to-back requests see each other's state.
// Reset: all state registers clear, the pump is off, manual mode is off and
//   the configuration returns to its defaults (30, 70, 60 s, 10 s).
// Stall: while the result is not taken the result register holds; the input
//   register still accepts one more request, after which ready drops.
// ----------------------------------------------------------------------------
module soil_moisture_pump_controller
    import smpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    smpc_sample_if.sink           sample,
    smpc_result_if.source         result
);

    // Configuration registers
    cfg_t        cfg_reg;

    // Input register
    logic                      s1_valid_reg;
    logic [TIME_W-1:0]         s1_now_reg;
    logic signed [MOIST_W-1:0] s1_moist_reg;
    logic                      s1_manual_reg;

    // Controller state
    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        fault;

    // Result register
    logic        res_valid_reg;
    logic        res_pump_reg;
    indicator_t  res_ind_reg;
    logic        res_manual_reg;
    logic        res_fault_reg;

    logic        advance;
    logic        take;

    // Advance the pass stage whenever the result register is free or drains
    assign advance      = !res_valid_reg || result.ready;
    assign sample.ready = !s1_valid_reg || advance;
    assign take         = sample.valid && sample.ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_threshold       <= LOW_THRESHOLD_RST;
            cfg_reg.high_threshold      <= HIGH_THRESHOLD_RST;
            cfg_reg.check_interval_s    <= CHECK_INTERVAL_RST;
            cfg_reg.watering_duration_s <= WATER_DURATION_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_LOW_THRESHOLD:  cfg_reg.low_threshold       <= cfg_data[THRESH_W-1:0];
                CFG_HIGH_THRESHOLD: cfg_reg.high_threshold      <= cfg_data[THRESH_W-1:0];
                CFG_CHECK_INTERVAL: cfg_reg.check_interval_s    <= cfg_data;
                CFG_WATER_DURATION: cfg_reg.watering_duration_s <= cfg_data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register: hold the request until the pass stage advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_now_reg    <= sample.now_seconds;
            s1_moist_reg  <= sample.moisture_percent;
            s1_manual_reg <= sample.manual_request;
        end
    end

    smpc_pass u_pass (
        .state            (state_reg),
        .cfg              (cfg_reg),
        .now_seconds      (s1_now_reg),
        .moisture_percent (s1_moist_reg),
        .manual_request   (s1_manual_reg),
        .state_next       (state_next),
        .fault            (fault)
    );

    // Controller state: commit the pass when its result is registered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.last_check_time <= '0;
            state_reg.pump_start_time <= '0;
            state_reg.last_water_time <= '0;
            state_reg.pump_on         <= 1'b0;
            state_reg.manual_mode     <= 1'b0;
            state_reg.indicator       <= IND_NORMAL;
        end
        else if (advance && s1_valid_reg)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            res_pump_reg   <= state_next.pump_on;
            res_ind_reg    <= state_next.indicator;
            res_manual_reg <= state_next.manual_mode;
            res_fault_reg  <= fault;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.pump_running  = res_pump_reg;
    assign result.indicator     = res_ind_reg;
    assign result.manual_active = res_manual_reg;
    assign result.sensor_fault  = res_fault_reg;

    // A faulty sample always drops the pump and manual mode
    a_fault_safe: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_fault_reg |->
            !res_pump_reg && !res_manual_reg && (res_ind_reg == IND_ERROR))
        else $error("fault result with pump or manual mode active");

    // The committed state matches the result just registered
    a_state_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_valid_reg |=>
            (res_pump_reg == state_reg.pump_on) &&
            (res_manual_reg == state_reg.manual_mode) &&
            (res_ind_reg == state_reg.indicator))
        else $error("result register out of step with controller state");

    // A held request never gets overwritten by a new one
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |-> !sample.ready)
        else $error("input register accepted over a held request");

    // The state only changes when a pass commits
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && s1_valid_reg) |=> $stable(state_reg))
        else $error("controller state changed without a pass");

endmodule

[tb/soil_moisture_pump_controller_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// soil_moisture_pump_controller_tb
// Self-checking bench for the pump controller. The bench queues sample
// requests, drives them over the valid/ready channel with random gaps, and
// predicts each pump result with its own model of the controller. Results
// are taken with random stalls and compared field by field. The run starts
// with a short directed sequence, then goes through several register
// settings, the extremes among them, with random requests.
// ----------------------------------------------------------------------------
module soil_moisture_pump_controller_tb;
    import smpc_pkg::*;

    // One sample request as the bench sees it
    typedef struct {
        logic [TIME_W-1:0]         now_s;
        logic signed [MOIST_W-1:0] moisture;
        logic                      manual;
    } sample_req_t;

    // One controller result
    typedef struct {
        logic       pump_running;
        indicator_t indicator;
        logic       manual_active;
        logic       sensor_fault;
    } pump_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    smpc_sample_if sample_ch ();
    smpc_result_if result_ch ();

    soil_moisture_pump_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample_ch),
        .result       (result_ch)
    );

    // Requests waiting to be offered, and the pump results they must produce
    sample_req_t  pending_q[$];
    pump_result_t expected_q[$];

    // Shadow copies of the control registers and the controller state
    cfg_t         cfg_shadow;
    ctrl_state_t  pump_model = '0;

    int           fail_count = 0;
    int           requests_issued;   // written by the stimulus process only
    int           requests_taken;    // written by the driver only
    int           results_seen;

    // Idle bookkeeping, each counter owned by one clocked process
    int           tx_gap;
    int           tx_calm;
    int           rx_hold;
    int           rx_calm;
    int           rx_long_hold;

    logic [TIME_W-1:0] wall_s;       // running time stamp for random requests

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: give up and report a failure if the run has not finished.
    initial
    begin
        #(5_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Pump controller model
    // ------------------------------------------------------------------------

    // Elapsed seconds, wrapping modulo 2^32 like the controller's counter
    function automatic logic [TIME_W-1:0] elapsed_s(input logic [TIME_W-1:0] now_s,
                                                   input logic [TIME_W-1:0] since_s);
        return now_s - since_s;
    endfunction

    function automatic void start_pump_model(input logic [TIME_W-1:0] now_s);
        pump_model.pump_on         = 1'b1;
        pump_model.indicator       = IND_WATERING;
        pump_model.pump_start_time = now_s;
        pump_model.last_water_time = now_s;
    endfunction

    function automatic void stop_pump_model();
        pump_model.pump_on   = 1'b0;
        pump_model.indicator = IND_NORMAL;
    endfunction

    // Advance the model by one controller pass and return the pump result
    function automatic pump_result_t run_pump_pass(input sample_req_t req);
        pump_result_t res;
        int           moist;
        logic         low_wanted;

        moist            = req.moisture;
        res.sensor_fault = 1'b0;

        // A manual request takes effect before the pass is judged
        if (req.manual)
            pump_model.manual_mode = 1'b1;

        if (moist < 0 || moist > int'(MOISTURE_MAX))
        begin
            // Sensor fault: kill the pump, drop manual mode, record no time
            res.sensor_fault       = 1'b1;
            pump_model.indicator   = IND_ERROR;
            pump_model.pump_on     = 1'b0;
            pump_model.manual_mode = 1'b0;
        end
        else if (pump_model.manual_mode)
        begin
            // Manual pass: no automatic check and no trailing duration check
            if (!pump_model.pump_on)
                start_pump_model(req.now_s);
            else if (elapsed_s(req.now_s, pump_model.pump_start_time) >=
                     cfg_shadow.watering_duration_s)
            begin
                stop_pump_model();
                pump_model.manual_mode = 1'b0;
            end
        end
        else
        begin
            if (elapsed_s(req.now_s, pump_model.last_check_time) >=
                cfg_shadow.check_interval_s)
            begin
                low_wanted = moist < int'(cfg_shadow.low_threshold);
                pump_model.last_check_time = req.now_s;
                if (low_wanted && elapsed_s(req.now_s, pump_model.last_water_time) >=
                    cfg_shadow.check_interval_s)
                    start_pump_model(req.now_s);
                else if (moist > int'(cfg_shadow.high_threshold))
                    stop_pump_model();
                else if (low_wanted)
                    pump_model.indicator = IND_LOW_ALERT;
                else if (!pump_model.pump_on)
                    pump_model.indicator = IND_NORMAL;
            end
            // A running pump always stops once its duration is up
            if (pump_model.pump_on &&
                elapsed_s(req.now_s, pump_model.pump_start_time) >=
                cfg_shadow.watering_duration_s)
                stop_pump_model();
        end

        res.pump_running  = pump_model.pump_on;
        res.indicator     = pump_model.indicator;
        res.manual_active = pump_model.manual_mode;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Idle pattern: mostly a random idle after each request, with calm
    // stretches where neither side idles at all
    // ------------------------------------------------------------------------
    function automatic int draw_wait(ref int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: offer queued requests, predict each one as it is taken
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        sample_req_t taken;
        sample_req_t next_req;
        logic        offering;

        if (!rst_n)
        begin
            sample_ch.valid            <= 1'b0;
            sample_ch.now_seconds      <= '0;
            sample_ch.moisture_percent <= '0;
            sample_ch.manual_request   <= 1'b0;
            tx_gap         = 0;
            tx_calm        = 0;
            requests_taken = 0;
        end
        else
        begin
            offering = sample_ch.valid;

            // Request accepted: predict its result and draw the next gap
            if (sample_ch.valid && sample_ch.ready)
            begin
                taken.now_s    = sample_ch.now_seconds;
                taken.moisture = sample_ch.moisture_percent;
                taken.manual   = sample_ch.manual_request;
                expected_q.push_back(run_pump_pass(taken));
                requests_taken++;
                offering = 1'b0;
                tx_gap   = draw_wait(tx_calm);
            end

            // Hold an offered request until taken; otherwise idle or offer the
            // next one. valid gets at most one assignment per edge here.
            if (!offering)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    sample_ch.valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    next_req = pending_q.pop_front();
                    sample_ch.now_seconds      <= next_req.now_s;
                    sample_ch.moisture_percent <= next_req.moisture;
                    sample_ch.manual_request   <= next_req.manual;
                    sample_ch.valid            <= 1'b1;
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: take results with random stalls and check them
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        pump_result_t want;

        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            rx_hold      = 0;
            rx_calm      = 0;
            rx_long_hold = 0;
            results_seen = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    $error("result taken with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("pump_running",  want.pump_running,  result_ch.pump_running);
                    check_field("indicator",     want.indicator,     result_ch.indicator);
                    check_field("manual_active", want.manual_active, result_ch.manual_active);
                    check_field("sensor_fault",  want.sensor_fault,  result_ch.sensor_fault);
                end
                rx_hold = draw_wait(rx_calm);
                // Now and then hold off for a long stretch so the controller
                // fills up and has to stall its request side
                if (results_seen % 300 == 150)
                    rx_long_hold = 80;
            end

            if (rx_long_hold > 0)
            begin
                rx_long_hold--;
                result_ch.ready <= 1'b0;
            end
            else if (rx_hold > 0)
            begin
                rx_hold--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic queue_req(input logic [TIME_W-1:0] now_s, input int moist,
                             input logic manual);
        sample_req_t req;
        req.now_s    = now_s;
        req.moisture = moist[MOIST_W-1:0];
        req.manual   = manual;
        pending_q.push_back(req);
        requests_issued++;
    endtask

    // Queue random passes. Time mostly moves forward in steps scaled to the
    // current interval and duration; a few jumps land anywhere, including
    // across the wrap. Samples are mostly valid, with some faults.
    task automatic queue_random(input int count);
        int span;
        int pick;
        int moist;

        span = (cfg_shadow.check_interval_s > cfg_shadow.watering_duration_s) ?
               int'(cfg_shadow.check_interval_s) : int'(cfg_shadow.watering_duration_s);
        span = span / 3 + 4;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                wall_s = $urandom();
            else if (pick >= 10)
                wall_s = wall_s + $urandom_range(0, span);

            pick = $urandom_range(0, 99);
            if (pick < 3)
                moist = ($urandom_range(0, 1) == 0) ? -32768 : 32767;
            else if (pick < 9)
            begin
                // Any 16-bit pattern outside 0..100
                moist = $signed(16'($urandom()));
                if (moist >= 0 && moist <= 100)
                    moist = 101 + moist;
            end
            else
                moist = $urandom_range(0, 100);

            queue_req(wall_s, moist, $urandom_range(0, 19) == 0);
        end
    endtask

    // Wait until every request has been taken and its result checked, then
    // give the pipeline time to settle
    task automatic wait_idle();
        while (requests_taken != requests_issued || expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one control register and mirror it in the shadow copy; the enable
    // stays high so back-to-back writes need only one assignment per edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        case (idx)
            CFG_LOW_THRESHOLD:  cfg_shadow.low_threshold       = data[THRESH_W-1:0];
            CFG_HIGH_THRESHOLD: cfg_shadow.high_threshold      = data[THRESH_W-1:0];
            CFG_CHECK_INTERVAL: cfg_shadow.check_interval_s    = data[INTERVAL_W-1:0];
            CFG_WATER_DURATION: cfg_shadow.watering_duration_s = data[INTERVAL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int low, input int high, input int interval,
                              input int duration);
        write_reg(CFG_LOW_THRESHOLD,  CFG_DATA_W'(low));
        write_reg(CFG_HIGH_THRESHOLD, CFG_DATA_W'(high));
        write_reg(CFG_CHECK_INTERVAL, CFG_DATA_W'(interval));
        write_reg(CFG_WATER_DURATION, CFG_DATA_W'(duration));
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic run_phase(input int low, input int high, input int interval,
                             input int duration);
        set_config(low, high, interval, duration);
        queue_random(135);
        wait_idle();
    endtask

    initial
    begin : stimulus
        // Every input known from time zero
        rst_n                      = 1'b0;
        cfg_write_en               = 1'b0;
        cfg_index                  = CFG_LOW_THRESHOLD;
        cfg_data                   = '0;
        requests_issued            = 0;
        wall_s                     = '0;

        cfg_shadow.low_threshold       = LOW_THRESHOLD_RST;
        cfg_shadow.high_threshold      = HIGH_THRESHOLD_RST;
        cfg_shadow.check_interval_s    = CHECK_INTERVAL_RST;
        cfg_shadow.watering_duration_s = WATER_DURATION_RST;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed sequence on the reset settings (30 %, 70 %, 60 s, 10 s)
        queue_req(32'd0,   50, 1'b0);           // no check due yet
        queue_req(32'd60,  10, 1'b0);           // check, dry: start watering
        queue_req(32'd65,  10, 1'b0);           // still running
        queue_req(32'd70,  10, 1'b0);           // duration up: stop
        queue_req(32'd130, 10, 1'b0);           // dry again: start
        queue_req(32'd135, 80, 1'b0);           // wet but no check due
        queue_req(32'd190, 80, 1'b0);           // check, wet: stop
        queue_req(32'd200, 50, 1'b1);           // manual request starts the pump
        queue_req(32'd205, 50, 1'b0);           // manual, still running
        queue_req(32'd215, 50, 1'b0);           // manual duration up: leave manual
        queue_req(32'd250, 10, 1'b0);           // dry, watered too recently: alert
        queue_req(32'd255, 101, 1'b0);          // just above range: fault
        queue_req(32'd256, -1, 1'b0);           // just below range: fault
        queue_req(32'd257, -32768, 1'b0);       // most negative sample
        queue_req(32'd258, 32767, 1'b1);        // fault drops a fresh manual request
        queue_req(32'd320, 100, 1'b0);          // top of range, above high threshold
        queue_req(32'd380, 0, 1'b0);            // bottom of range: start
        queue_req(32'd385, 0, 1'b1);            // manual while the pump is on
        queue_req(32'd400, 0, 1'b0);            // manual stop
        queue_req(32'hFFFF_FFF0, 0, 1'b0);      // near the wrap: start
        queue_req(32'h0000_0005, 45, 1'b0);     // duration measured across the wrap
        queue_req(32'hFFFF_FFFF, 45, 1'b0);     // all ones time stamp
        wall_s = 32'hFFFF_FFFF;
        wait_idle();

        // Register settings, extremes first: zero interval and zero duration,
        // then everything at its maximum, then a spread of ordinary ones
        run_phase(0,   0,   0,     0);
        run_phase(127, 127, 65535, 65535);
        run_phase(50,  60,  20,    5);
        run_phase(20,  80,  5,     30);          // pump outlives the check interval
        run_phase(100, 10,  1,     0);           // low above high
        repeat (3)
            run_phase($urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(0, 200), $urandom_range(0, 100));
        run_phase(int'(LOW_THRESHOLD_RST), int'(HIGH_THRESHOLD_RST),
                  int'(CHECK_INTERVAL_RST), int'(WATER_DURATION_RST));

        // Nothing should trickle out after the last result
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
